// File: design/gne_pkg.sv
// ============================================================================
// gne_pkg
// shared types, constants and arithmetic helpers of the gradient noise core
// ============================================================================
package gne_pkg;

   // pipeline shape
   localparam int NUM_STAGES  = 8;
   localparam int STG_WRITE   = 2;   // write beats update the table leaving this stage
   localparam int STG_READ    = 3;   // table read data and fade weights land here
   localparam int STG_DOT     = 4;   // corner dot products
   localparam int STG_OUT     = NUM_STAGES - 1;
   localparam int NUM_CORNERS = 4;

   // request beat layout
   localparam int ADDR_W     = 8;
   localparam int COORD_W    = 16;
   localparam int REQ_DATA_W = 48;
   localparam int ADDR_LSB   = 0;
   localparam int DIR_LSB    = 8;
   localparam int X_LSB      = 10;
   localparam int Y_LSB      = 26;
   localparam int NOISE_W    = 16;

   // fixed point
   localparam int T_W        = 16;
   localparam int S_W        = 17;
   localparam int PQ_W       = 20;
   localparam int DOT_W      = 18;
   localparam int DIFF_W     = 19;
   localparam int Q16_ONE    = 65536;
   localparam int ROUND_HALF = 32768;
   localparam int NOISE_MAX  = 65535;
   localparam int FADE_C6    = 6;
   localparam int FADE_C15   = 15;
   localparam int FADE_C10   = 10;

   // item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_EVAL  = 1'b1;

   typedef enum logic [1:0] {
      DIR_POS_X = 2'd0,
      DIR_POS_Y = 2'd1,
      DIR_NEG_X = 2'd2,
      DIR_NEG_Y = 2'd3
   } dir_type;

   typedef logic signed [DOT_W-1:0] dot_type;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] addr;
      dir_type           dir;
   } item_ctl_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      dir_type           dir;
   } tbl_wr_type;

   // gradient dotted with corner offset
   function automatic dot_type corner_dot(dir_type dir, dot_type dx, dot_type dy);
      dot_type res;
      unique case (dir)
         DIR_POS_X: res = dx;
         DIR_POS_Y: res = dy;
         DIR_NEG_X: res = -dx;
         DIR_NEG_Y: res = -dy;
      endcase
      return res;
   endfunction

   // a + round_half_up((b - a) * s / 2^16), one product
   function automatic dot_type lerp_q16(dot_type a, dot_type b, logic [S_W-1:0] s);
      logic signed [DIFF_W-1:0]    d;
      logic signed [DIFF_W+S_W:0]  prod;
      logic signed [DIFF_W+S_W+1:0] acc;
      d    = DIFF_W'(b) - DIFF_W'(a);
      prod = d * $signed({1'b0, s});
      acc  = ((DIFF_W+S_W+2)'(a) <<< 16) + (DIFF_W+S_W+2)'(prod)
           + (DIFF_W+S_W+2)'(ROUND_HALF);
      return DOT_W'(acc >>> 16);
   endfunction

endpackage

// File: design/gne_index.sv
// ============================================================================
// gne_index
// integer part of one coordinate wrapped onto the grid, plus the next cell
// ============================================================================
module gne_index #(
   parameter int GRID_SIZE = 16,
   parameter int FRAC_BITS = 8
) (
   input  logic                         clock,
   input  logic [1:0]                   load,
   input  logic [gne_pkg::COORD_W-1:0]  coord,
   output logic [$clog2(GRID_SIZE)-1:0] cell_lo,
   output logic [$clog2(GRID_SIZE)-1:0] cell_hi
);
   import gne_pkg::*;

   localparam int CW    = $clog2(GRID_SIZE);
   localparam int IW    = (FRAC_BITS < COORD_W) ? COORD_W - FRAC_BITS : 1;
   localparam int MW    = ((IW > CW) ? IW : CW) + 1;
   localparam int RECIP = 65536 / GRID_SIZE;

   logic [IW-1:0]    ip_in, ip_ff;
   logic [IW+15:0]   qp_in, qp_ff;
   logic [IW-1:0]    quot;
   logic [MW-1:0]    qg, r_est, rem;
   logic [CW-1:0]    lo_in, hi_in, lo_ff, hi_ff;

   // quotient estimate by reciprocal, at most one low
   assign ip_in = IW'(coord >> FRAC_BITS);
   assign qp_in = (IW+16)'(ip_in) * (IW+16)'(RECIP);

   always_ff @(posedge clock) begin
      if (load[0]) begin
         ip_ff <= ip_in;
         qp_ff <= qp_in;
      end
   end

   // remainder with one correction step
   always_comb begin
      quot  = qp_ff[IW+15:16];
      qg    = MW'(quot) * MW'(GRID_SIZE);
      r_est = MW'(ip_ff) - qg;
      rem   = (r_est >= MW'(GRID_SIZE)) ? r_est - MW'(GRID_SIZE) : r_est;
      lo_in = CW'(rem);
      hi_in = (rem == MW'(GRID_SIZE - 1)) ? '0 : CW'(rem + MW'(1));
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign cell_lo = lo_ff;
   assign cell_hi = hi_ff;

endmodule

// File: design/gne_fade.sv
// ============================================================================
// gne_fade
// quintic fade weight 6t^5-15t^4+10t^3 in Q16, four register stages
// ============================================================================
module gne_fade (
   input  logic                     clock,
   input  logic [3:0]               load,
   input  logic [gne_pkg::T_W-1:0]  t_in,
   output logic [gne_pkg::T_W-1:0]  t_out,
   output logic [gne_pkg::S_W-1:0]  s_out
);
   import gne_pkg::*;

   logic [T_W-1:0]  t0_ff, t1_ff, t2_ff, t3_ff;
   logic [31:0]     tt0_ff;
   logic [T_W-1:0]  u1, u2;
   logic [36:0]     p;
   logic [PQ_W-1:0] pq1_in, pq1_ff;
   logic [31:0]     uu1_in, uu1_ff;
   logic [35:0]     prod2_in, prod2_ff;
   logic [S_W-1:0]  s3_in, s3_ff;

   // stage 0: square
   always_ff @(posedge clock) begin
      if (load[0]) begin
         t0_ff  <= t_in;
         tt0_ff <= 32'(t_in) * 32'(t_in);
      end
   end

   // stage 1: polynomial part and cube
   always_comb begin
      u1     = T_W'((tt0_ff + 32'(ROUND_HALF)) >> 16);
      p      = (37'(FADE_C10) << 32) + 37'(tt0_ff) * 37'(FADE_C6)
             - ((37'(t0_ff) * 37'(FADE_C15)) << 16);
      pq1_in = PQ_W'((p + 37'(ROUND_HALF)) >> 16);
      uu1_in = 32'(u1) * 32'(t0_ff);
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         t1_ff  <= t0_ff;
         pq1_ff <= pq1_in;
         uu1_ff <= uu1_in;
      end
   end

   // stage 2: cube times polynomial
   always_comb begin
      u2       = T_W'((uu1_ff + 32'(ROUND_HALF)) >> 16);
      prod2_in = 36'(u2) * 36'(pq1_ff);
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         t2_ff    <= t1_ff;
         prod2_ff <= prod2_in;
      end
   end

   // stage 3: round to Q16
   assign s3_in = S_W'((37'(prod2_ff) + 37'(ROUND_HALF)) >> 16);

   always_ff @(posedge clock) begin
      if (load[3]) begin
         t3_ff <= t2_ff;
         s3_ff <= s3_in;
      end
   end

   assign t_out = t3_ff;
   assign s_out = s3_ff;

endmodule

// File: design/gne_table.sv
// ============================================================================
// gne_table
// gradient table, one copy per cell corner so all four read in the same cycle
// ============================================================================
module gne_table #(
   parameter int GRID_SIZE = 16
) (
   input  logic                                           clock,
   input  logic [1:0]                                     load,
   input  gne_pkg::tbl_wr_type                            wr_req,
   input  logic [$clog2(GRID_SIZE)-1:0]                   x_lo,
   input  logic [$clog2(GRID_SIZE)-1:0]                   x_hi,
   input  logic [$clog2(GRID_SIZE)-1:0]                   y_lo,
   input  logic [$clog2(GRID_SIZE)-1:0]                   y_hi,
   output gne_pkg::dir_type [gne_pkg::NUM_CORNERS-1:0]    corner_dir
);
   import gne_pkg::*;

   localparam int CW        = $clog2(GRID_SIZE);
   localparam int AWF       = 2 * CW;
   localparam int DEPTH     = GRID_SIZE * GRID_SIZE;
   localparam int MEM_DEPTH = (DEPTH > 256) ? 256 : DEPTH;
   localparam int AW        = $clog2(MEM_DEPTH);

   logic [CW-1:0] row_sel [NUM_CORNERS];
   logic [CW-1:0] col_sel [NUM_CORNERS];
   logic [AW-1:0] idx_in  [NUM_CORNERS];
   logic [AW-1:0] idx_ff  [NUM_CORNERS];
   logic          wr_fire;
   logic [AW-1:0] wr_addr;

   // corners: top-left, top-right, bottom-left, bottom-right
   always_comb begin
      row_sel[0] = y_lo;  col_sel[0] = x_lo;
      row_sel[1] = y_lo;  col_sel[1] = x_hi;
      row_sel[2] = y_hi;  col_sel[2] = x_lo;
      row_sel[3] = y_hi;  col_sel[3] = x_hi;
      for (int c = 0; c < NUM_CORNERS; c++) begin
         idx_in[c] = AW'(AWF'(row_sel[c]) * AWF'(GRID_SIZE) + AWF'(col_sel[c]));
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         idx_ff <= idx_in;
      end
   end

   // out-of-range write addresses are dropped
   assign wr_fire = load[1] && wr_req.en && (int'(wr_req.addr) < DEPTH);
   assign wr_addr = AW'(wr_req.addr);

   for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_copy
      dir_type grad_mem_ff [MEM_DEPTH];
      dir_type rd_ff;

      always_ff @(posedge clock) begin
         if (wr_fire) begin
            grad_mem_ff[wr_addr] <= wr_req.dir;
         end
         if (load[1]) begin
            rd_ff <= grad_mem_ff[idx_ff[c]];
         end
      end

      assign corner_dir[c] = rd_ff;
   end

endmodule

// File: design/gne_blend.sv
// ============================================================================
// gne_blend
// corner dot products, two lerp levels and the final mapping to Q0.16
// ============================================================================
module gne_blend (
   input  logic                                         clock,
   input  logic [3:0]                                   load,
   input  gne_pkg::dir_type [gne_pkg::NUM_CORNERS-1:0]  corner_dir,
   input  logic [gne_pkg::T_W-1:0]                      tx,
   input  logic [gne_pkg::T_W-1:0]                      ty,
   input  logic [gne_pkg::S_W-1:0]                      sx,
   input  logic [gne_pkg::S_W-1:0]                      sy,
   output logic [gne_pkg::NOISE_W-1:0]                  noise
);
   import gne_pkg::*;

   dot_type                fx, fy, gx, gy;
   dot_type                dot_in [NUM_CORNERS];
   dot_type                dot_ff [NUM_CORNERS];
   logic [S_W-1:0]         sx4_ff, sy4_ff, sx5_ff;
   dot_type                left_ff, right_ff, v_ff;
   logic signed [DOT_W:0]  w, half;
   logic [NOISE_W-1:0]     noise_in, noise_ff;

   // offsets to the near and far corners
   always_comb begin
      fx = $signed(DOT_W'(tx));
      fy = $signed(DOT_W'(ty));
      gx = fx - DOT_W'(Q16_ONE);
      gy = fy - DOT_W'(Q16_ONE);
      dot_in[0] = corner_dot(corner_dir[0], fx, fy);
      dot_in[1] = corner_dot(corner_dir[1], gx, fy);
      dot_in[2] = corner_dot(corner_dir[2], fx, gy);
      dot_in[3] = corner_dot(corner_dir[3], gx, gy);
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         dot_ff <= dot_in;
         sx4_ff <= sx;
         sy4_ff <= sy;
      end
   end

   // vertical blend, left and right columns side by side
   always_ff @(posedge clock) begin
      if (load[1]) begin
         left_ff  <= lerp_q16(dot_ff[0], dot_ff[2], sy4_ff);
         right_ff <= lerp_q16(dot_ff[1], dot_ff[3], sy4_ff);
         sx5_ff   <= sx4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         v_ff <= lerp_q16(left_ff, right_ff, sx5_ff);
      end
   end

   // (v + 1) / 2 in Q16, clamped
   always_comb begin
      w    = (DOT_W+1)'(v_ff) + (DOT_W+1)'(Q16_ONE + 1);
      half = w >>> 1;
      priority if (int'(half) < 0) begin
         noise_in = '0;
      end else if (int'(half) > NOISE_MAX) begin
         noise_in = NOISE_W'(NOISE_MAX);
      end else begin
         noise_in = NOISE_W'(half);
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         noise_ff <= noise_in;
      end
   end

   assign noise = noise_ff;

endmodule

// File: design/gradient_noise_2d_eval_core.sv
// ============================================================================
// gradient_noise_2d_eval_core
// 2d gradient noise with quintic fade over a wrapping grid of unit gradients
// ============================================================================
// Each request beat is either a table write (tuser = 0), which stores one
// gradient direction and returns nothing, or an evaluation (tuser = 1), which
// returns one rsp beat holding the noise at (x, y) as unsigned Q0.16. The core
// takes one beat per clock while the output is not stalled and has
// eight register stages, so an evaluation shows on rsp_tvalid once it
// has passed through each of them in turn; the depth comes from the fade,
// which chains three multiplications one after another, and the
// two levels of linear blending behind the table read. rsp_tready back-pressure
// ripples up the stage valid chain, so empty stages keep filling while a
// result waits. The gradient table is held in four copies, one per cell
// corner, all written together; a write takes effect for every beat accepted
// after it. The table has no reset: evaluating a cell whose corners were
// never written gives an undefined value.
// ============================================================================
module gradient_noise_2d_eval_core #(
   parameter int GRID_SIZE = 16,
   parameter int FRAC_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: table_address[7:0], direction[9:8], x_coord[25:10], y_coord[41:26],
   //        zero pad[47:42]
   input  logic [gne_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: kind[0] (0 = table write, 1 = evaluate)
   input  logic                              req_tuser,
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: noise_value[15:0]
   output logic [gne_pkg::NOISE_W-1:0]       rsp_tdata
);
   import gne_pkg::*;

   localparam int CW = $clog2(GRID_SIZE);

   // stage control
   logic [NUM_STAGES-1:0] valid_ff, valid_in, valid_up, ready;
   item_ctl_type          ctl_ff [STG_READ+1];
   item_ctl_type          ctl_new;
   tbl_wr_type            wr_req;

   // datapath links
   logic [COORD_W-1:0]    x_coord, y_coord;
   logic [T_W-1:0]        tx_in, ty_in, tx_rd, ty_rd;
   logic [S_W-1:0]        sx_rd, sy_rd;
   logic [CW-1:0]         x_lo, x_hi, y_lo, y_hi;
   dir_type [NUM_CORNERS-1:0] corner_dir;
   logic [NOISE_W-1:0]    noise;

   // unpack the request beat
   assign x_coord = req_tdata[X_LSB +: COORD_W];
   assign y_coord = req_tdata[Y_LSB +: COORD_W];
   assign ctl_new = '{kind: req_tuser,
                      addr: req_tdata[ADDR_LSB +: ADDR_W],
                      dir:  dir_type'(req_tdata[DIR_LSB +: 2])};

   // fraction widened to Q16, integer bits drop off the top
   assign tx_in = T_W'(x_coord << (T_W - FRAC_BITS));
   assign ty_in = T_W'(y_coord << (T_W - FRAC_BITS));

   // a stage loads when it is empty or its successor moves
   always_comb begin
      ready[STG_OUT] = !valid_ff[STG_OUT] || rsp_tready;
      for (int k = STG_OUT - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   // write beats retire once the table has taken them
   always_comb begin
      valid_up[0] = req_tvalid && !reset;
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_up[k] = valid_ff[k-1];
      end
      valid_up[STG_DOT] = valid_ff[STG_READ] && (ctl_ff[STG_READ].kind == KIND_EVAL);
      for (int k = 0; k < NUM_STAGES; k++) begin
         valid_in[k] = ready[k] ? valid_up[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // kind, address and direction ride along until the table stage
   always_ff @(posedge clock) begin
      if (ready[0]) begin
         ctl_ff[0] <= ctl_new;
      end
      for (int k = 1; k <= STG_READ; k++) begin
         if (ready[k]) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   assign wr_req = '{en:   valid_ff[STG_WRITE] && (ctl_ff[STG_WRITE].kind == KIND_WRITE),
                     addr: ctl_ff[STG_WRITE].addr,
                     dir:  ctl_ff[STG_WRITE].dir};

   // cell indices, wrapped, two stages
   gne_index #(
      .GRID_SIZE (GRID_SIZE),
      .FRAC_BITS (FRAC_BITS)
   ) u_index_x (
      .clock   (clock),
      .load    (ready[1:0]),
      .coord   (x_coord),
      .cell_lo (x_lo),
      .cell_hi (x_hi)
   );

   gne_index #(
      .GRID_SIZE (GRID_SIZE),
      .FRAC_BITS (FRAC_BITS)
   ) u_index_y (
      .clock   (clock),
      .load    (ready[1:0]),
      .coord   (y_coord),
      .cell_lo (y_lo),
      .cell_hi (y_hi)
   );

   // fade weights, four stages, in step with the table read
   gne_fade u_fade_x (
      .clock (clock),
      .load  (ready[3:0]),
      .t_in  (tx_in),
      .t_out (tx_rd),
      .s_out (sx_rd)
   );

   gne_fade u_fade_y (
      .clock (clock),
      .load  (ready[3:0]),
      .t_in  (ty_in),
      .t_out (ty_rd),
      .s_out (sy_rd)
   );

   // corner addresses then registered read; writes land on the same edge
   gne_table #(
      .GRID_SIZE (GRID_SIZE)
   ) u_table (
      .clock      (clock),
      .load       (ready[3:2]),
      .wr_req     (wr_req),
      .x_lo       (x_lo),
      .x_hi       (x_hi),
      .y_lo       (y_lo),
      .y_hi       (y_hi),
      .corner_dir (corner_dir)
   );

   // dot products, blends and output register
   gne_blend u_blend (
      .clock      (clock),
      .load       (ready[7:4]),
      .corner_dir (corner_dir),
      .tx         (tx_rd),
      .ty         (ty_rd),
      .sx         (sx_rd),
      .sy         (sy_rd),
      .noise      (noise)
   );

   assign req_tready = ready[0] && !reset;
   assign rsp_tvalid = valid_ff[STG_OUT];
   assign rsp_tdata  = noise;

endmodule

// File: design/gne_checker.sv
// ============================================================================
// gne_checker
// port-level checks of the gradient noise core, bound to the top level
// ============================================================================
module gne_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [gne_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                           req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [gne_pkg::NOISE_W-1:0]    rsp_tdata
);
   import gne_pkg::*;

   logic acc_eval;

   assign acc_eval = req_tvalid && req_tready && (req_tuser == KIND_EVAL);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // no result survives reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // a free output lets the whole pipe take a beat
   a_full_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_tready || !rsp_tvalid) |-> req_tready)
      else $error("req stalled with output free");

   // unstalled evaluation appears after eight stages
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (acc_eval && rsp_tready) ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid)
      else $error("evaluation result missing");

   // a stalled request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("req beat changed while stalled");

endmodule

bind gradient_noise_2d_eval_core gne_checker u_gne_checker (.*);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// self-checking bench for the 2d gradient noise core
// ============================================================================
// Table write beats and evaluation beats go in on the req stream. A small
// class keeps its own copy of the gradient table and works out the expected
// noise for every accepted evaluation. Each rsp beat is compared with the
// oldest pending value. Stimulus is a short directed list, then random mixes.
// Before an evaluation, any of its cell corners not yet written gets a write
// first. Idling on both sides changes across three phases.
// ============================================================================
module testbench;
   import gne_pkg::*;

   localparam int GRID         = 16;
   localparam int FRAC         = 8;
   localparam int TABLE_DEPTH  = GRID * GRID;
   localparam int FRAC_MASK    = (1 << FRAC) - 1;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 2 * NUM_STAGES + 8;
   localparam int PHASE_BEATS  = 192;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [NOISE_W-1:0]    rsp_tdata;

   // noise predictor with its own gradient table and pending results
   class gradient_field;
      dir_type            grad_dirs[TABLE_DEPTH];
      logic [NOISE_W-1:0] noise_due[$];
      int unsigned        mismatches;
      int unsigned        writes_seen;
      int unsigned        evals_seen;
      int unsigned        results_checked;

      // quintic fade 6t^5-15t^4+10t^3 in q16
      function longint fade_weight(longint t);
         longint p, pq, u;
         p  = FADE_C6 * t * t - FADE_C15 * t * Q16_ONE + FADE_C10 * (longint'(1) << 32);
         pq = (p + ROUND_HALF) >>> 16;
         u  = (t * t + ROUND_HALF) >>> 16;
         u  = (u * t + ROUND_HALF) >>> 16;
         return (u * pq + ROUND_HALF) >>> 16;
      endfunction

      // offset keeps the numerator positive so the shift rounds half up
      function longint blend(longint a, longint b, longint s);
         longint num;
         num = a * (Q16_ONE - s) + b * s + (longint'(1) << 33) + ROUND_HALF;
         return (num >>> 16) - (longint'(1) << 17);
      endfunction

      function longint gradient_dot(int unsigned row, int unsigned col,
                                    longint dx, longint dy);
         case (grad_dirs[row * GRID + col])
            DIR_POS_X: return dx;
            DIR_POS_Y: return dy;
            DIR_NEG_X: return -dx;
            default:   return -dy;
         endcase
      endfunction

      function logic [NOISE_W-1:0] noise_at(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
         int unsigned col0, row0, col1, row1;
         longint tx, ty, tl, tr, bl, br, sx, sy, left, right, v;
         col0 = (x >> FRAC) % GRID;
         row0 = (y >> FRAC) % GRID;
         col1 = (col0 + 1) % GRID;
         row1 = (row0 + 1) % GRID;
         tx   = longint'(x & FRAC_MASK) << (16 - FRAC);
         ty   = longint'(y & FRAC_MASK) << (16 - FRAC);
         tl   = gradient_dot(row0, col0, tx, ty);
         tr   = gradient_dot(row0, col1, tx - Q16_ONE, ty);
         bl   = gradient_dot(row1, col0, tx, ty - Q16_ONE);
         br   = gradient_dot(row1, col1, tx - Q16_ONE, ty - Q16_ONE);
         sx   = fade_weight(tx);
         sy   = fade_weight(ty);
         left  = blend(tl, bl, sy);
         right = blend(tr, br, sy);
         v     = blend(left, right, sx);
         // map -1..1 to 0..1, top end saturates
         v = (v + Q16_ONE + 1) / 2;
         if (v < 0) v = 0;
         if (v > NOISE_MAX) v = NOISE_MAX;
         return NOISE_W'(v);
      endfunction

      function void take_request(logic kind, logic [ADDR_W-1:0] addr, dir_type dir,
                                 logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
         if (kind == KIND_WRITE) begin
            if (addr < TABLE_DEPTH) grad_dirs[addr] = dir;
            writes_seen++;
         end else begin
            noise_due.push_back(noise_at(x, y));
            evals_seen++;
         end
      endfunction

      function void check_noise(logic [NOISE_W-1:0] got);
         logic [NOISE_W-1:0] want;
         if (noise_due.size() == 0) begin
            $error("noise_value beat with no evaluation pending: expected none, actual %0d",
                   got);
            mismatches++;
            return;
         end
         want = noise_due.pop_front();
         results_checked++;
         if (got !== want) begin
            $error("noise_value mismatch: expected %0d, actual %0d", want, got);
            mismatches++;
         end
      endfunction
   endclass

   gradient_field grid_model = new();

   bit          loaded[TABLE_DEPTH];   // entries written so far, stimulus side
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned beats_sent;

   gradient_noise_2d_eval_core #(
      .GRID_SIZE (GRID),
      .FRAC_BITS (FRAC)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial forever #1 clock = ~clock;

   // result side: check the beat taken at this edge, then pick the next ready
   always @(posedge clock) begin
      if (rsp_tvalid === 1'b1 && rsp_tready) grid_model.check_noise(rsp_tdata);
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // one req beat, with random idle cycles ahead of it
   task automatic send_beat(input logic kind, input logic [ADDR_W-1:0] addr,
                            input dir_type dir, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y);
      logic [REQ_DATA_W-1:0] data;
      data = '0;
      data[ADDR_LSB +: ADDR_W] = addr;
      data[DIR_LSB +: 2]       = dir;
      data[X_LSB +: COORD_W]   = x;
      data[Y_LSB +: COORD_W]   = y;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (req_tready !== 1'b1);
      grid_model.take_request(kind, addr, dir, x, y);
      beats_sent++;
   endtask

   task automatic load_entry(input int unsigned addr, input dir_type dir);
      send_beat(KIND_WRITE, ADDR_W'(addr), dir, COORD_W'($urandom), COORD_W'($urandom));
      if (addr < TABLE_DEPTH) loaded[addr] = 1'b1;
   endtask

   // writes any unwritten corner of the cell first, never reads an empty entry
   task automatic evaluate_at(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      int unsigned col0, row0, col1, row1;
      int unsigned corners[NUM_CORNERS];
      col0 = (x >> FRAC) % GRID;
      row0 = (y >> FRAC) % GRID;
      col1 = (col0 + 1) % GRID;
      row1 = (row0 + 1) % GRID;
      corners = '{row0 * GRID + col0, row0 * GRID + col1,
                  row1 * GRID + col0, row1 * GRID + col1};
      foreach (corners[i]) begin
         if (!loaded[corners[i]]) load_entry(corners[i], dir_type'($urandom_range(3)));
      end
      send_beat(KIND_EVAL, ADDR_W'($urandom), dir_type'($urandom_range(3)), x, y);
   endtask

   // q8.8 coordinate biased toward fraction extremes and the wrapping column
   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(5))
         0:       return {8'($urandom), 8'h00};
         1:       return {8'($urandom), 8'hff};
         2:       return {8'($urandom), 8'h80};
         3:       return {4'($urandom), 4'hf, 8'($urandom)};
         default: return COORD_W'($urandom);
      endcase
   endfunction

   task automatic run_directed();
      // cell (0,0), one corner per direction
      load_entry(0, DIR_POS_X);
      load_entry(1, DIR_POS_Y);
      load_entry(16, DIR_NEG_X);
      load_entry(17, DIR_NEG_Y);
      // remaining corners of the wrapping cell (15,15), top entry included
      load_entry(15, DIR_NEG_Y);
      load_entry(240, DIR_POS_Y);
      load_entry(255, DIR_NEG_X);
      evaluate_at(16'h0000, 16'h0000);
      evaluate_at(16'h00ff, 16'h00ff);
      evaluate_at(16'h0080, 16'h0080);
      evaluate_at(16'h00ff, 16'h0000);
      evaluate_at(16'h0000, 16'h00ff);
      // next corner wraps back to column and row zero
      evaluate_at(16'h0f80, 16'h0f80);
      evaluate_at(16'h0f00, 16'h0f00);
      // integer part far beyond the grid
      evaluate_at(16'hffff, 16'hffff);
      evaluate_at(16'h1080, 16'h2040);
      // rewrite of a live entry is seen by the next evaluation
      load_entry(0, DIR_NEG_X);
      evaluate_at(16'h0040, 16'h00c0);
   endtask

   task automatic run_random(input int unsigned beats);
      int unsigned stop_at;
      stop_at = beats_sent + beats;
      while (beats_sent < stop_at) begin
         if ($urandom_range(99) < 30) begin
            load_entry($urandom_range(TABLE_DEPTH - 1), dir_type'($urandom_range(3)));
         end else begin
            evaluate_at(pick_coord(), pick_coord());
         end
      end
   endtask

   // watchdog on cycles with no beat moving on either side
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("gradient_noise_2d_eval_core test failed");
      $finish;
   end

   initial begin
      send_idle_pct = 23;
      recv_idle_pct = 51;
      beats_sent    = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(PHASE_BEATS);
      send_idle_pct = 51;
      recv_idle_pct = 23;
      run_random(PHASE_BEATS);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(PHASE_BEATS);
      req_tvalid <= 1'b0;

      // drain, then let any stray beat show up
      while (grid_model.noise_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d req beats: %0d table writes, %0d evaluations",
               beats_sent, grid_model.writes_seen, grid_model.evals_seen);
      $display("%0d noise results checked over three idling mixes, %0d mismatches",
               grid_model.results_checked, grid_model.mismatches);
      if (grid_model.mismatches == 0) begin
         $display("gradient_noise_2d_eval_core test passed");
      end else begin
         $display("gradient_noise_2d_eval_core test failed");
      end
      $finish;
   end

endmodule

// File: sim.f
design/gne_pkg.sv
design/gne_index.sv
design/gne_fade.sv
design/gne_table.sv
design/gne_blend.sv
design/gradient_noise_2d_eval_core.sv
design/gne_checker.sv
dv/testbench.sv
